@@ design/rpn_pkg.sv @@
// Shared constants and types for the RPN stack calculator.
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int ACT_W       = 3;
  localparam int ERR_W       = 2;
  localparam int DEPTH_W     = 5;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ITER_W      = $clog2(DATA_W);

  localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd3;

  typedef struct packed {
    logic             start;
    logic [ACT_W-1:0] op;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

endpackage

@@ design/rpn_stack_calculator.sv @@
// Push, error cases and unknown actions report in the cycle after the item is accepted.
// Add, subtract, multiply and divide pass through a stack read state, one iteration per data
// bit and a finishing state in the serial arithmetic unit, and a write-back that registers
// the result. Throughput: one push per cycle while idle; no item is taken while an operator runs.
// The done strobe lasts one cycle and cannot be held off. Reset empties the stack and
// idles the controller; stored entries are not cleared.
module rpn_stack_calculator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  output logic                        done,
  input  logic [rpn_pkg::ACT_W-1:0]   action,
  input  logic signed [rpn_pkg::DATA_W-1:0] number,
  output logic signed [rpn_pkg::DATA_W-1:0] top_value,
  output logic [rpn_pkg::DEPTH_W-1:0] depth,
  output logic [rpn_pkg::ERR_W-1:0]   error
);

  localparam int W  = rpn_pkg::DATA_W;
  localparam int CW = rpn_pkg::CNT_W;
  localparam int AW = rpn_pkg::ADDR_W;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_WAIT} state_t;

  state_t                    state;
  logic [CW-1:0]             cnt;
  logic [W-1:0]              top;
  logic [rpn_pkg::ACT_W-1:0] op;
  logic                      accept;
  logic                      full;
  logic                      ram_we;
  logic [CW-1:0]             waddr_full;
  logic [CW-1:0]             raddr_full;
  logic [W-1:0]              ram_rdata;
  logic [W-1:0]              top_shown;
  rpn_pkg::alu_ctrl_t        alu_ctrl;
  rpn_pkg::alu_stat_t        alu_stat;
  logic [W-1:0]              alu_result;

  // The top entry lives in a register; the RAM holds the entries beneath it.
  assign accept     = start && (state == S_IDLE);
  assign full       = (cnt >= CW'(rpn_pkg::STACK_DEPTH));
  assign ram_we     = accept && (action == rpn_pkg::ACT_PUSH) && !full && (cnt != '0);
  assign waddr_full = cnt - 1'b1;
  assign raddr_full = cnt - CW'(2);
  assign top_shown  = (cnt == '0) ? '0 : top;
  assign busy       = (state != S_IDLE);

  assign alu_ctrl.start = (state == S_LOAD);
  assign alu_ctrl.op    = op;

  rpn_ram #(
    .WIDTH (W),
    .DEPTH (rpn_pkg::STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_full[AW-1:0]),
    .wdata (top),
    .raddr (raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  rpn_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (alu_ctrl),
    .a      (ram_rdata),
    .b      (top),
    .stat   (alu_stat),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            priority if (action == rpn_pkg::ACT_PUSH) begin
              done <= 1'b1;
              if (full) begin
                top_value <= top_shown;
                depth     <= rpn_pkg::DEPTH_W'(cnt);
                error     <= rpn_pkg::ERR_OVER;
              end else begin
                top       <= W'(number);
                cnt       <= cnt + 1'b1;
                top_value <= number;
                depth     <= rpn_pkg::DEPTH_W'(cnt + 1'b1);
                error     <= rpn_pkg::ERR_OK;
              end
            end else if (action == rpn_pkg::ACT_ADD || action == rpn_pkg::ACT_SUB ||
                         action == rpn_pkg::ACT_MUL || action == rpn_pkg::ACT_DIV) begin
              if (cnt < CW'(2)) begin
                done      <= 1'b1;
                top_value <= top_shown;
                depth     <= rpn_pkg::DEPTH_W'(cnt);
                error     <= rpn_pkg::ERR_UNDER;
              end else if (action == rpn_pkg::ACT_DIV && top == '0) begin
                done      <= 1'b1;
                top_value <= top_shown;
                depth     <= rpn_pkg::DEPTH_W'(cnt);
                error     <= rpn_pkg::ERR_DIV0;
              end else begin
                op    <= action;
                state <= S_LOAD;
              end
            end else begin
              // Unknown action codes leave the stack alone.
              done      <= 1'b1;
              top_value <= top_shown;
              depth     <= rpn_pkg::DEPTH_W'(cnt);
              error     <= rpn_pkg::ERR_OK;
            end
          end
        end
        S_LOAD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_stat.done) begin
            top       <= alu_result;
            cnt       <= cnt - 1'b1;
            done      <= 1'b1;
            top_value <= alu_result;
            depth     <= rpn_pkg::DEPTH_W'(cnt - 1'b1);
            error     <= rpn_pkg::ERR_OK;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the controller is busy");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(rpn_pkg::STACK_DEPTH))
    else $error("stack count beyond capacity");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    (done && error == rpn_pkg::ERR_OVER) |-> (cnt == CW'(rpn_pkg::STACK_DEPTH)))
    else $error("overflow reported on a stack that is not full");

  a_alu_in_wait: assert property (@(posedge clk) disable iff (rst)
    (alu_stat.busy || alu_stat.done) |-> (state == S_WAIT))
    else $error("arithmetic unit active outside the wait state");

endmodule

@@ design/rpn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rpn_alu.sv @@
// Serial arithmetic unit: add and subtract a bit per cycle, multiply and divide radix 2.
module rpn_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  rpn_pkg::alu_ctrl_t         ctrl,
  input  logic [rpn_pkg::DATA_W-1:0] a,
  input  logic [rpn_pkg::DATA_W-1:0] b,
  output rpn_pkg::alu_stat_t         stat,
  output logic [rpn_pkg::DATA_W-1:0] result
);

  localparam int W = rpn_pkg::DATA_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t                        state;
  logic [rpn_pkg::ACT_W-1:0]     op;
  logic [W-1:0]                  ra;
  logic [W-1:0]                  rb;
  logic [W-1:0]                  res;
  logic [W-1:0]                  rem;
  logic                          carry;
  logic                          neg;
  logic                          done;
  logic [rpn_pkg::ITER_W-1:0]    iter;
  logic                          sum_bit;
  logic                          carry_next;
  logic [W:0]                    shifted;
  logic [W:0]                    trial;

  assign sum_bit    = ra[0] ^ rb[0] ^ carry;
  assign carry_next = (ra[0] & rb[0]) | (carry & (ra[0] ^ rb[0]));
  assign shifted    = {rem, ra[W-1]};
  assign trial      = shifted - {1'b0, rb};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            op    <= ctrl.op;
            iter  <= '0;
            res   <= '0;
            rem   <= '0;
            neg   <= a[W-1] ^ b[W-1];
            carry <= (ctrl.op == rpn_pkg::ACT_SUB);
            state <= S_RUN;
            if (ctrl.op == rpn_pkg::ACT_DIV) begin
              ra <= a[W-1] ? (W'(0) - a) : a;
              rb <= b[W-1] ? (W'(0) - b) : b;
            end else if (ctrl.op == rpn_pkg::ACT_SUB) begin
              ra <= a;
              rb <= ~b;
            end else begin
              ra <= a;
              rb <= b;
            end
          end
        end
        S_RUN: begin
          if (op == rpn_pkg::ACT_MUL) begin
            if (rb[0]) begin
              res <= res + ra;
            end
            ra <= {ra[W-2:0], 1'b0};
            rb <= {1'b0, rb[W-1:1]};
          end else if (op == rpn_pkg::ACT_DIV) begin
            // Restoring division: the dividend register fills with quotient bits.
            if (!trial[W]) begin
              rem <= trial[W-1:0];
              ra  <= {ra[W-2:0], 1'b1};
            end else begin
              rem <= shifted[W-1:0];
              ra  <= {ra[W-2:0], 1'b0};
            end
          end else begin
            res   <= {sum_bit, res[W-1:1]};
            carry <= carry_next;
            ra    <= {1'b0, ra[W-1:1]};
            rb    <= {1'b0, rb[W-1:1]};
          end
          iter <= iter + 1'b1;
          if (iter == rpn_pkg::ITER_W'(W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (op == rpn_pkg::ACT_DIV) begin
            result <= neg ? (W'(0) - ra) : ra;
          end else begin
            result <= res;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = done;

endmodule

@@ verif/rpn_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the RPN stack calculator: tracks the stack, predicts and compares.
module rpn_result_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              done,
  input  logic [rpn_pkg::ACT_W-1:0]         action,
  input  logic signed [rpn_pkg::DATA_W-1:0] number,
  input  logic signed [rpn_pkg::DATA_W-1:0] top_value,
  input  logic [rpn_pkg::DEPTH_W-1:0]       depth,
  input  logic [rpn_pkg::ERR_W-1:0]         error,
  output int                                fail_count,
  output int                                pending
);

  typedef struct packed {
    logic signed [rpn_pkg::DATA_W-1:0] top;
    logic [rpn_pkg::DEPTH_W-1:0]       depth;
    logic [rpn_pkg::ERR_W-1:0]         err;
  } calc_result_t;

  logic signed [rpn_pkg::DATA_W-1:0] calc_stack [rpn_pkg::STACK_DEPTH];
  int unsigned                       calc_count;
  calc_result_t                      result_q [$];
  int                                mismatch_count;

  // Signed division that truncates toward zero, done on magnitudes so that
  // the most negative value over minus one wraps back to itself.
  function automatic logic [rpn_pkg::DATA_W-1:0] quotient_trunc(
    logic [rpn_pkg::DATA_W-1:0] dividend,
    logic [rpn_pkg::DATA_W-1:0] divisor);
    logic [rpn_pkg::DATA_W-1:0] mag_n;
    logic [rpn_pkg::DATA_W-1:0] mag_d;
    logic [rpn_pkg::DATA_W-1:0] quot;
    mag_n = dividend[rpn_pkg::DATA_W-1] ? -dividend : dividend;
    mag_d = divisor[rpn_pkg::DATA_W-1] ? -divisor : divisor;
    quot  = mag_n / mag_d;
    return (dividend[rpn_pkg::DATA_W-1] ^ divisor[rpn_pkg::DATA_W-1]) ? -quot : quot;
  endfunction

  function automatic calc_result_t apply_item(logic [rpn_pkg::ACT_W-1:0] act,
                                              logic signed [rpn_pkg::DATA_W-1:0] val);
    calc_result_t                      res;
    logic signed [rpn_pkg::DATA_W-1:0] lhs;
    logic signed [rpn_pkg::DATA_W-1:0] rhs;
    logic signed [rpn_pkg::DATA_W-1:0] value;
    res.err = rpn_pkg::ERR_OK;
    value   = '0;
    if (act == rpn_pkg::ACT_PUSH) begin
      if (calc_count >= rpn_pkg::STACK_DEPTH) begin
        res.err = rpn_pkg::ERR_OVER;
      end else begin
        calc_stack[calc_count] = val;
        calc_count++;
      end
    end else if (act <= rpn_pkg::ACT_DIV) begin
      if (calc_count < 2) begin
        res.err = rpn_pkg::ERR_UNDER;
      end else begin
        rhs = calc_stack[calc_count - 1];
        lhs = calc_stack[calc_count - 2];
        case (act)
          rpn_pkg::ACT_ADD: value = lhs + rhs;
          rpn_pkg::ACT_SUB: value = lhs - rhs;
          rpn_pkg::ACT_MUL: value = lhs * rhs;
          default: begin
            if (rhs == 0) res.err = rpn_pkg::ERR_DIV0;
            else value = quotient_trunc(lhs, rhs);
          end
        endcase
        if (res.err == rpn_pkg::ERR_OK) begin
          calc_count--;
          calc_stack[calc_count - 1] = value;
        end
      end
    end
    // Codes above divide leave the stack alone and just report it.
    res.top   = (calc_count == 0) ? '0 : calc_stack[calc_count - 1];
    res.depth = rpn_pkg::DEPTH_W'(calc_count);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    calc_result_t want;
    calc_result_t got;
    if (rst) begin
      calc_count = 0;
      result_q.delete();
      mismatch_count = 0;
    end else begin
      // Results leave in order and always after the edge that takes their item,
      // so the result is matched before this edge's item is queued.
      if (done) begin
        got = '{top: top_value, depth: depth, err: error};
        if (result_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result: top %0d depth %0d error %0d",
                     $realtime, got.top, got.depth, got.err);
          mismatch_count++;
        end else begin
          want = result_q.pop_front();
          if (got.top !== want.top || got.depth !== want.depth || got.err !== want.err) begin
            if (mismatch_count < 10)
              $display("%0t: mismatch: top %0d/%0d depth %0d/%0d error %0d/%0d (exp/act)",
                       $realtime, want.top, got.top, want.depth, got.depth,
                       want.err, got.err);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) result_q.push_back(apply_item(action, number));
    end
    pending    <= result_q.size();
    fail_count <= mismatch_count;
  end

endmodule

@@ verif/tb_rpn_stack_calculator.sv @@
`timescale 1ns / 100ps
// Testbench top for the RPN stack calculator: clock, reset, item stimulus and verdict.
module tb_rpn_stack_calculator;

  localparam int RUN_LIMIT    = 200000;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 450;

  localparam logic [rpn_pkg::ACT_W-1:0] ACT_IGNORED_LO = 3'd5;
  localparam logic [rpn_pkg::ACT_W-1:0] ACT_IGNORED_HI = 3'd7;

  localparam logic signed [rpn_pkg::DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [rpn_pkg::DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} item_mix_t;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic                              done;
  logic [rpn_pkg::ACT_W-1:0]         action;
  logic signed [rpn_pkg::DATA_W-1:0] number;
  logic signed [rpn_pkg::DATA_W-1:0] top_value;
  logic [rpn_pkg::DEPTH_W-1:0]       depth;
  logic [rpn_pkg::ERR_W-1:0]         error;

  int fail_count;
  int pending;
  int cycle_count = 0;
  bit gaps_on     = 1'b1;

  rpn_stack_calculator u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .action    (action),
    .number    (number),
    .top_value (top_value),
    .depth     (depth),
    .error     (error)
  );

  rpn_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .action     (action),
    .number     (number),
    .top_value  (top_value),
    .depth      (depth),
    .error      (error),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Holds the item on the inputs until the block takes it and is no longer busy.
  task automatic send_item(input logic [rpn_pkg::ACT_W-1:0] act,
                           input logic signed [rpn_pkg::DATA_W-1:0] val);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 26) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start  <= 1'b1;
    action <= act;
    number <= val;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic signed [rpn_pkg::DATA_W-1:0] pick_number();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 1;
      2:       return -1;
      3:       return INT_MIN;
      4:       return INT_MAX;
      5, 6:    return $signed($urandom_range(0, 40)) - 20;
      default: return $urandom();
    endcase
  endfunction

  initial begin : stimulus
    item_mix_t                 mix;
    int                        seg_left;
    int                        push_pct;
    int                        roll;
    logic [rpn_pkg::ACT_W-1:0] act;
    rst    <= 1'b1;
    start  <= 1'b0;
    action <= rpn_pkg::ACT_PUSH;
    number <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_item(rpn_pkg::ACT_ADD, 32'sd5);        // operator on an empty stack
    send_item(rpn_pkg::ACT_PUSH, INT_MIN);
    send_item(rpn_pkg::ACT_DIV, '0);            // operator with a single entry
    send_item(rpn_pkg::ACT_PUSH, -32'sd1);
    send_item(rpn_pkg::ACT_DIV, '0);            // most negative over minus one wraps
    send_item(rpn_pkg::ACT_PUSH, INT_MAX);
    send_item(rpn_pkg::ACT_ADD, INT_MAX);
    send_item(rpn_pkg::ACT_PUSH, '0);
    send_item(rpn_pkg::ACT_DIV, '0);            // divide by zero keeps the stack
    send_item(rpn_pkg::ACT_MUL, INT_MIN);
    send_item(rpn_pkg::ACT_PUSH, 32'sd7);
    send_item(rpn_pkg::ACT_PUSH, -32'sd2);
    send_item(rpn_pkg::ACT_DIV, '0);            // truncates toward zero
    send_item(rpn_pkg::ACT_SUB, '0);
    send_item(ACT_IGNORED_LO, INT_MAX);
    send_item(ACT_IGNORED_HI, -32'sd1);
    send_item(rpn_pkg::ACT_PUSH, INT_MAX);
    send_item(rpn_pkg::ACT_MUL, '0);            // multiply wraps
    send_item(rpn_pkg::ACT_PUSH, INT_MIN);
    send_item(rpn_pkg::ACT_SUB, '0);            // subtract wraps

    // Segments lean toward pushes, toward operators or to neither, so the stack swings
    // between full and empty and both overflow and underflow come up.
    mix      = MIX_EVEN;
    seg_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (seg_left == 0) begin
        mix      = item_mix_t'($urandom_range(0, 2));
        seg_left = $urandom_range(10, 40);
      end
      seg_left--;
      gaps_on = !(i >= 150 && i < 300);
      case (mix)
        MIX_FILL:  push_pct = 85;
        MIX_DRAIN: push_pct = 20;
        default:   push_pct = 50;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3) act = rpn_pkg::ACT_W'($urandom_range(ACT_IGNORED_LO, ACT_IGNORED_HI));
      else if (roll < 3 + push_pct) act = rpn_pkg::ACT_PUSH;
      else act = rpn_pkg::ACT_W'($urandom_range(rpn_pkg::ACT_ADD, rpn_pkg::ACT_DIV));
      send_item(act, pick_number());
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ rpn_stack_calculator.f @@
design/rpn_pkg.sv
design/rpn_ram.sv
design/rpn_alu.sv
design/rpn_stack_calculator.sv
verif/rpn_result_checker.sv
verif/tb_rpn_stack_calculator.sv
